// ===== sv/grey_morphology_3x3_top_assert.svh =====
// Assertion macros for the 3x3 grey morphology block.
// Used by grey_morphology_3x3_top; expects i_clk and i_rst_n in scope.
`ifndef GREY_MORPHOLOGY_3X3_TOP_ASSERT_SVH
`define GREY_MORPHOLOGY_3X3_TOP_ASSERT_SVH

// same-cycle implication
`define GM3_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gm3 assertion failed");

// next-cycle implication
`define GM3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gm3 assertion failed");

`endif

// ===== sv/gm3_pkg.sv =====
// Shared types, constants and kernel functions for the 3x3 grey morphology block.
// No dependencies.
`default_nettype none
package gm3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int SE_W    = 36;
    localparam int LW_W    = 11;              // line_width register
    localparam int OUT_W   = 10;              // out_row / out_col fields
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W   = COL_W + 1;       // column count that can hold the width
    localparam int PIX_MAX = 255;

    localparam logic [SE_W-1:0] SE_RESET = 36'h301213321;
    localparam logic [LW_W-1:0] LW_RESET = 11'd640;

    typedef enum logic [1:0] {
        OP_DIL  = 2'd0,
        OP_ERO  = 2'd1,
        OP_GRAD = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_OP_MODE    = 2'd0,
        CFG_SE_WEIGHTS = 2'd1,
        CFG_LINE_WIDTH = 2'd2
    } t_cfg_idx;

    typedef logic [8:0][PIX_W-1:0] t_win;

    // pixel as placed by the raster scanner
    typedef struct packed {
        logic             valid;
        logic             produce;
        logic [PIX_W-1:0] px;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_scan_item;

    // window centre tag
    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
    } t_tag;

    function automatic logic [PIX_W-1:0] f_max(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] f_min(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // max of (pixel + weight), each term saturated at full scale
    function automatic logic [PIX_W-1:0] f_dilate(t_win win, logic [SE_W-1:0] se);
        logic [PIX_W:0]             s;
        logic [8:0][PIX_W-1:0]      v;
        logic [PIX_W-1:0]           m0, m1, m2, m3, m4, m5, m6;
        for (int k = 0; k < 9; k++) begin
            s    = {1'b0, win[k]} + {{(PIX_W-3){1'b0}}, se[4*k +: 4]};
            v[k] = s[PIX_W] ? PIX_W'(PIX_MAX) : s[PIX_W-1:0];
        end
        m0 = f_max(v[0], v[1]);
        m1 = f_max(v[2], v[3]);
        m2 = f_max(v[4], v[5]);
        m3 = f_max(v[6], v[7]);
        m4 = f_max(m0, m1);
        m5 = f_max(m2, m3);
        m6 = f_max(m4, m5);
        return f_max(m6, v[8]);
    endfunction

    // min of (pixel - weight), each term clamped at zero
    function automatic logic [PIX_W-1:0] f_erode(t_win win, logic [SE_W-1:0] se);
        logic [PIX_W-1:0]           wt;
        logic [8:0][PIX_W-1:0]      v;
        logic [PIX_W-1:0]           m0, m1, m2, m3, m4, m5, m6;
        for (int k = 0; k < 9; k++) begin
            wt   = {{(PIX_W-4){1'b0}}, se[4*k +: 4]};
            v[k] = (win[k] >= wt) ? (win[k] - wt) : '0;
        end
        m0 = f_min(v[0], v[1]);
        m1 = f_min(v[2], v[3]);
        m2 = f_min(v[4], v[5]);
        m3 = f_min(v[6], v[7]);
        m4 = f_min(m0, m1);
        m5 = f_min(m2, m3);
        m6 = f_min(m4, m5);
        return f_min(m6, v[8]);
    endfunction

endpackage
`default_nettype wire

// ===== sv/gm3_ram.sv =====
// Generic single-write, single-read synchronous RAM, read-first, registered read.
// No dependencies.
`default_nettype none
module gm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];   // old data on same-address write
        end
    end

endmodule
`default_nettype wire

// ===== sv/gm3_scan.sv =====
// Raster scanner: column/row counters, frame restart, width clamp, height cutoff.
// Depends on gm3_pkg.
`default_nettype none
module gm3_scan
    import gm3_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic             i_frame_start,
    input  wire logic [LW_W-1:0]  i_line_width,
    output t_scan_item            o_item,
    output logic [COL_W-1:0]      o_col,
    output logic [ROW_W-1:0]      o_row
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] w_eff;
    logic [COL_W-1:0] c1;
    logic [ROW_W-1:0] r1;
    logic [CNT_W-1:0] c_next;
    logic             drop;

    always_comb begin
        priority if (32'(i_line_width) < 32'd3) begin
            w_eff = CNT_W'(3);
        end else if (32'(i_line_width) > 32'(MAX_WIDTH)) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(i_line_width);
        end
    end

    always_comb begin
        c1   = i_frame_start ? '0 : r_col;
        r1   = i_frame_start ? '0 : r_row;
        drop = 1'b0;
        if (32'(r1) >= 32'(MAX_HEIGHT)) begin
            drop = 1'b1;
        end else if ({1'b0, c1} >= w_eff) begin
            // width lowered mid-row: close the row first
            c1 = '0;
            r1 = r1 + 1'b1;
            if (32'(r1) >= 32'(MAX_HEIGHT)) begin
                drop = 1'b1;
            end
        end
        c_next = {1'b0, c1} + 1'b1;
        if (drop) begin
            n_col = c1;
            n_row = r1;
        end else if (c_next >= w_eff) begin
            n_col = '0;
            n_row = r1 + 1'b1;
        end else begin
            n_col = c_next[COL_W-1:0];
            n_row = r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_item.valid   = i_accept && !drop;
        o_item.produce = (32'(r1) >= 32'd2) && (32'(c1) >= 32'd2);
        o_item.px      = i_pixel;
        o_item.col     = c1;
        o_item.row     = r1;
    end

    assign o_col = r_col;
    assign o_row = r_row;

endmodule
`default_nettype wire

// ===== sv/gm3_line_buf.sv =====
// Two line stores (read-modify-write with forwarding) and the 3x3 window.
// Depends on gm3_pkg and gm3_ram.
`default_nettype none
module gm3_line_buf
    import gm3_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  t_scan_item i_item,
    output t_win       o_win,
    output t_tag       o_tag
);

    t_scan_item       r_s1;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_top, r_fwd_mid;
    logic [PIX_W-1:0] rd_a, rd_b, s1_top, s1_mid;
    logic             s1_go;
    t_win             r_win;
    t_tag             r_tag;

    assign s1_go  = i_en && r_s1.valid;
    // read issued in the same cycle as the previous write to that column
    assign s1_mid = r_fwd ? r_fwd_mid : rd_a;
    assign s1_top = r_fwd ? r_fwd_top : rd_b;

    gm3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1.col),
        .i_wdata (r_s1.px),
        .i_re    (i_item.valid),
        .i_raddr (i_item.col),
        .o_rdata (rd_a)
    );

    gm3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1.col),
        .i_wdata (s1_mid),
        .i_re    (i_item.valid),
        .i_raddr (i_item.col),
        .o_rdata (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1.produce <= i_item.produce;
            r_s1.px      <= i_item.px;
            r_s1.col     <= i_item.col;
            r_s1.row     <= i_item.row;
            r_fwd_top    <= s1_mid;
            r_fwd_mid    <= r_s1.px;
            r_tag.row    <= OUT_W'(r_s1.row - 1'b1);
            r_tag.col    <= OUT_W'(r_s1.col - 1'b1);
        end
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_s1.valid  <= i_item.valid;
            r_fwd       <= i_item.valid && r_s1.valid && (r_s1.col == i_item.col);
            r_tag.valid <= r_s1.valid && r_s1.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_go) begin
            for (int k = 0; k < 3; k++) begin
                r_win[3*k]     <= r_win[3*k + 1];
                r_win[3*k + 1] <= r_win[3*k + 2];
            end
            r_win[2] <= s1_top;
            r_win[5] <= s1_mid;
            r_win[8] <= r_s1.px;
        end
    end

    assign o_win = r_win;
    assign o_tag = r_tag;

endmodule
`default_nettype wire

// ===== sv/gm3_kernel.sv =====
// Weighted max/min over the window, mode select and the output register.
// Depends on gm3_pkg.
`default_nettype none
module gm3_kernel
    import gm3_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  t_win                  i_win,
    input  t_tag                  i_tag,
    input  wire logic [1:0]       i_op_mode,
    input  wire logic [SE_W-1:0]  i_se_weights,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_pixel,
    output logic [OUT_W-1:0]      o_row,
    output logic [OUT_W-1:0]      o_col
);

    t_tag             r_s3_tag;
    logic [PIX_W-1:0] r_dil, r_ero;
    logic [PIX_W-1:0] n_pixel;
    logic             r_valid;
    logic [PIX_W-1:0] r_pixel;
    logic [OUT_W-1:0] r_row, r_col;

    always_comb begin
        unique case (i_op_mode)
            OP_DIL:  n_pixel = r_dil;
            OP_ERO:  n_pixel = r_ero;
            default: n_pixel = (r_dil > r_ero) ? (r_dil - r_ero) : '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_tag.row <= i_tag.row;
            r_s3_tag.col <= i_tag.col;
            r_dil        <= f_dilate(i_win, i_se_weights);
            r_ero        <= f_erode(i_win, i_se_weights);
            r_pixel      <= n_pixel;
            r_row        <= r_s3_tag.row;
            r_col        <= r_s3_tag.col;
        end
        if (!i_rst_n) begin
            r_s3_tag.valid <= 1'b0;
            r_valid        <= 1'b0;
        end else if (i_en) begin
            r_s3_tag.valid <= i_tag.valid;
            r_valid        <= r_s3_tag.valid;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_row   = r_row;
    assign o_col   = r_col;

endmodule
`default_nettype wire

// ===== sv/grey_morphology_3x3_top.sv =====
// Top level of the 3x3 grey morphology block: config registers, flow control, wiring.
// Depends on gm3_pkg, gm3_scan, gm3_line_buf, gm3_kernel and the assertion macro header.
//
// Usage:
//  - s_axis: one 8-bit grey pixel per transfer in raster order; tuser = frame start.
//  - m_axis: one result per window lying fully inside the image; tdata carries the
//    saturated result with the row and column of the window centre.
//  - cfg: write channel (index, data), always ready: 0 op_mode, 1 se_weights,
//    2 line_width. Write only while the stream is idle.
//  - Throughput: one pixel per clock while no result waits on a stalled m_axis.
//    A result reaches m_axis through four register stages (line store read,
//    window, weighted max/min, output reg); the first loads at its pixel's accepting edge.
//  - Line stores are read at the pixel column and written back from the next stage;
//    a read that meets the write of the same column takes the forwarded data.
//  - Reset clears counters, window and pipeline valids and restores config
//    defaults (dilation, weights 1,2,3,3,1,2,1,0,3, width 640). Line stores
//    are not cleared; entries are written before they reach a result.
//  - Stall: the whole pipeline freezes while a result waits and m_axis_tready
//    is low; s_axis_tready falls in that case and is high otherwise.
//  - Rows past the height limit are taken and dropped until the next frame start.
`default_nettype none
`include "grey_morphology_3x3_top_assert.svh"
module grey_morphology_3x3_top
    import gm3_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  wire logic        s_axis_tuser,   // [0] frame_start
    // result out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] out_pixel, [17:8] out_row, [27:18] out_col
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [35:0] i_cfg_data
);

    logic [1:0]       r_op_mode;
    logic [SE_W-1:0]  r_se_weights;
    logic [LW_W-1:0]  r_line_width;

    logic             w_en;
    logic             w_accept;
    t_scan_item       w_item;
    logic [COL_W-1:0] w_scan_col;
    logic [ROW_W-1:0] w_scan_row;
    t_win             w_win;
    t_tag             w_tag;
    logic             w_out_valid;
    logic [PIX_W-1:0] w_out_pixel;
    logic [OUT_W-1:0] w_out_row, w_out_col;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode    <= OP_DIL;
            r_se_weights <= SE_RESET;
            r_line_width <= LW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_OP_MODE:    r_op_mode    <= i_cfg_data[1:0];
                CFG_SE_WEIGHTS: r_se_weights <= i_cfg_data;
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data[LW_W-1:0];
                default:        ;  // unused index
            endcase
        end
    end

    // pipeline advances whenever the output register is free or being drained
    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;

    gm3_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_line_width  (r_line_width),
        .o_item        (w_item),
        .o_col         (w_scan_col),
        .o_row         (w_scan_row)
    );

    gm3_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_item  (w_item),
        .o_win   (w_win),
        .o_tag   (w_tag)
    );

    gm3_kernel u_kernel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_win        (w_win),
        .i_tag        (w_tag),
        .i_op_mode    (r_op_mode),
        .i_se_weights (r_se_weights),
        .o_valid      (w_out_valid),
        .o_pixel      (w_out_pixel),
        .o_row        (w_out_row),
        .o_col        (w_out_col)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {4'b0000, w_out_col, w_out_row, w_out_pixel};

    // a waiting result blocks intake
    `GM3_ASSERT_SAME(a_hold_intake, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // results never sit on the image border
    `GM3_ASSERT_SAME(a_center_inside, m_axis_tvalid, (w_out_row != '0) && (w_out_col != '0))
    // a placed pixel always lies below the height limit
    `GM3_ASSERT_SAME(a_row_bound, w_item.valid, 32'(w_item.row) < 32'(MAX_HEIGHT))
    // frame start restarts the raster at pixel (0,0)
    `GM3_ASSERT_NEXT(a_frame_restart, w_accept && s_axis_tuser,
                     (w_scan_col == COL_W'(1)) && (w_scan_row == '0))

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for grey_morphology_3x3_top: raster pixels go in, window results are checked.
// A local model of the line stores, window and counters predicts every result in order.
// Depends on gm3_pkg and the block's RTL.
module tb;
    import gm3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;   // unused mode code, acts as gradient
    localparam int MIN_WIDTH  = 3;
    localparam int SETTLE     = 8;            // pipeline is 4 deep; round up

    typedef struct packed {
        logic       sof;
        logic [7:0] level;
    } t_pixel_item;

    typedef struct packed {
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] level;
    } t_window_result;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RUNS} t_rx_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr = '0;
    logic [35:0] i_cfg_data = '0;

    grey_morphology_3x3_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Local model state: config copy, line stores, window, raster counters
    // ---------------------------------------------------------------------
    logic [1:0]       mode_q  = OP_DIL;
    logic [35:0]      se_q    = SE_RESET;
    logic [10:0]      lw_q    = LW_RESET;
    logic [7:0]       row_m1 [MAX_WIDTH] = '{default: '0};   // previous row
    logic [7:0]       row_m2 [MAX_WIDTH] = '{default: '0};   // row before that
    logic [7:0]       win    [9]         = '{default: '0};
    int unsigned      col_cnt = 0;
    int unsigned      row_cnt = 0;

    t_pixel_item      pixel_backlog [$];
    t_window_result   window_results [$];
    int               pixels_queued = 0;
    int               pixels_taken  = 0;
    int               mismatch_count = 0;
    int               gen_width = 640;    // effective width the stimulus is built for
    bit               px_fire = 1'b0;     // pixel transfer seen at the last rising edge

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // One pixel through the raster scanner, line stores and 3x3 window.
    function automatic void predict_window(input logic [7:0] px, input logic sof,
                                           output bit hit, output t_window_result res);
        int unsigned w, c, r;
        int          d, e, wt, k;
        logic [7:0]  top, mid;
        hit = 1'b0;
        res = '0;
        w = lw_q;
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (sof) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (row_cnt >= MAX_HEIGHT) return;
        // width lowered under the running column: close the row first
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= MAX_HEIGHT) return;
        end
        c = col_cnt;
        r = row_cnt;
        top = row_m2[c];
        mid = row_m1[c];
        row_m2[c] = mid;
        row_m1[c] = px;
        for (k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        if (r >= 2 && c >= 2) begin
            d = 0;
            e = 255;
            for (k = 0; k < 9; k++) begin
                wt = se_q[4*k +: 4];
                if (int'(win[k]) + wt > d) d = int'(win[k]) + wt;
                if (int'(win[k]) - wt < e) e = int'(win[k]) - wt;
            end
            if (d > 255) d = 255;
            if (e < 0) e = 0;
            case (mode_q)
                OP_DIL:  res.level = 8'(d);
                OP_ERO:  res.level = 8'(e);
                default: res.level = (d > e) ? 8'(d - e) : 8'd0;
            endcase
            res.row = 10'(r - 1);
            res.col = 10'(c - 1);
            hit = 1'b1;
        end
        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Monitor: config writes, result check, prediction on pixel transfers
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        bit             hit;
        t_window_result want;
        t_window_result fresh;
        px_fire = s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_OP_MODE:    mode_q = i_cfg_data[1:0];
                    CFG_SE_WEIGHTS: se_q   = i_cfg_data;
                    CFG_LINE_WIDTH: lw_q   = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (window_results.size() == 0) begin
                    report_mismatch("unexpected result, col field", m_axis_tdata[27:18], '0);
                end else begin
                    want = window_results.pop_front();
                    if (m_axis_tdata[7:0] !== want.level)
                        report_mismatch("out_pixel", m_axis_tdata[7:0], want.level);
                    if (m_axis_tdata[17:8] !== want.row)
                        report_mismatch("out_row", m_axis_tdata[17:8], want.row);
                    if (m_axis_tdata[27:18] !== want.col)
                        report_mismatch("out_col", m_axis_tdata[27:18], want.col);
                end
            end
            if (px_fire) begin
                pixels_taken++;
                predict_window(s_axis_tdata, s_axis_tuser, hit, fresh);
                if (hit) window_results.push_back(fresh);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Pixel driver: bursts of random length, random gaps between them
    // ---------------------------------------------------------------------
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(negedge i_clk) begin : pixel_driver
        t_pixel_item next_px;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || px_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
                next_px = pixel_backlog.pop_front();
                s_axis_tdata  <= next_px.level;
                s_axis_tuser  <= next_px.sof;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result receiver: backpressure style, picked at random from four, changes over the run
    // ---------------------------------------------------------------------
    t_rx_style   rx_style   = RX_OPEN;
    int          style_left = 0;
    int          run_left   = 0;
    bit          run_ready  = 1'b1;

    always @(negedge i_clk) begin : result_sink
        if (style_left == 0) begin
            rx_style   = t_rx_style'($urandom_range(0, 3));
            style_left = $urandom_range(50, 400);
        end else begin
            style_left--;
        end
        case (rx_style)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                // alternating open and stalled stretches
                if (run_left == 0) begin
                    run_ready = !run_ready;
                    run_left  = $urandom_range(1, 12);
                end else begin
                    run_left--;
                end
                m_axis_tready <= run_ready;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 15));
            3:       return 8'($urandom_range(240, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input logic [7:0] level, input logic sof);
        t_pixel_item item;
        item.level = level;
        item.sof   = sof;
        pixel_backlog.push_back(item);
        pixels_queued++;
    endtask

    task automatic queue_pixels(input int count, input bit sof_first);
        int i;
        for (i = 0; i < count; i++) push_pixel(pick_level(), sof_first && (i == 0));
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [35:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LINE_WIDTH) begin
            gen_width = val[10:0];
            if (gen_width < MIN_WIDTH) gen_width = MIN_WIDTH;
            if (gen_width > MAX_WIDTH) gen_width = MAX_WIDTH;
        end
    endtask

    function automatic logic [35:0] random_weights();
        return {4'($urandom_range(0, 15)), 32'($urandom)};
    endfunction

    // Wait until every queued pixel is taken and every result is back, then let
    // the pipeline settle; results that never show up are failures.
    task automatic drain(input int settle);
        int             waited;
        t_window_result lost;
        waited = 0;
        while (pixels_taken != pixels_queued) @(negedge i_clk);
        while (window_results.size() != 0 && waited < 400) begin
            @(negedge i_clk);
            waited++;
        end
        while (window_results.size() != 0) begin
            lost = window_results.pop_front();
            report_mismatch("missing result, row field", 'x, lost.row);
        end
        repeat (settle) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] corner_px [9];
        int         ph, k, target, pick;
        corner_px = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd240, 8'd1};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: 640 wide, dilation, default weights, no frame start
        queue_pixels(2 * 640 + 8, 1'b0);
        drain(SETTLE);

        // width under the minimum, full weights: dilation saturates high
        write_reg(CFG_LINE_WIDTH, 36'd2);
        write_reg(CFG_SE_WEIGHTS, {36{1'b1}});
        write_reg(CFG_OP_MODE, 36'(OP_DIL));
        for (k = 0; k < 9; k++) push_pixel(corner_px[k], k == 0);
        drain(SETTLE);
        // same frame continues: erosion clamps at zero
        write_reg(CFG_OP_MODE, 36'(OP_ERO));
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd15, 1'b0);
        push_pixel(8'd14, 1'b0);
        drain(SETTLE);
        // unused mode code behaves as gradient
        write_reg(CFG_OP_MODE, 36'(OP_SPARE));
        write_reg(CFG_SE_WEIGHTS, random_weights());
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd128, 1'b0);
        drain(SETTLE);
        // width lowered mid-row: row closes before the next pixel
        write_reg(CFG_LINE_WIDTH, 36'd4);
        queue_pixels(7, 1'b1);
        drain(SETTLE);
        write_reg(CFG_LINE_WIDTH, 36'd1);
        queue_pixels(3, 1'b0);
        drain(SETTLE);

        // random phases: mostly whole frames, some cut short or running on
        for (ph = 0; ph < 4; ph++) begin
            write_reg(CFG_LINE_WIDTH, ($urandom_range(0, 3) == 0) ?
                      36'($urandom_range(0, 2)) : 36'($urandom_range(3, 12)));
            write_reg(CFG_OP_MODE, 36'($urandom_range(0, 3)));
            write_reg(CFG_SE_WEIGHTS, random_weights());
            target = pixels_queued + 50;
            pick = 0;   // a phase always opens with a frame start
            while (pixels_queued < target) begin
                if (pick < 7)
                    queue_pixels(gen_width * $urandom_range(3, 4), 1'b1);
                else if (pick == 7)
                    queue_pixels($urandom_range(1, 2 * gen_width), 1'b1);
                else
                    queue_pixels($urandom_range(1, gen_width), 1'b0);
                pick = $urandom_range(0, 8);
            end
            drain(SETTLE);
        end

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
